// ===== sv/qft_pkg.sv =====
// shared types and constants for the quoted field tokenizer
package qft_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned MAP_W       = 256;
   localparam int unsigned QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MID_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MID_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HIGH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP        = 3'd4;

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

   typedef enum logic [3:0] {
      QM_NONE   = 4'b0001,
      QM_ESC    = 4'b0010,
      QM_SINGLE = 4'b0100,
      QM_DOUBLE = 4'b1000
   } quote_type;

   typedef struct packed {
      logic [MAP_W-1:0] delim_map;
      logic             group_delims;
   } csr_type;

   // classified byte as it travels from front to back
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              is_delim;
      logic              is_bslash;
      logic              is_squote;
      logic              is_dquote;
   } item_type;

endpackage

// ===== sv/qft_channels.sv =====
// stream channels of the quoted field tokenizer

interface qft_req_if;
   logic                        valid;
   logic                        ready;
   logic [qft_pkg::CHAR_W-1:0]  char_in;
   logic                        last_char;

   modport source(output valid, output char_in, output last_char, input ready);
   modport sink(input valid, input char_in, input last_char, output ready);
endinterface

interface qft_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qft_pkg::CHAR_W-1:0]  out_char;
   logic                        out_char_valid;
   logic                        field_end;
   logic                        stream_end;

   modport source(output valid, output out_char, output out_char_valid,
                  output field_end, output stream_end, input ready);
   modport sink(input valid, input out_char, input out_char_valid,
                input field_end, input stream_end, output ready);
endinterface

// ===== sv/qft_csr.sv =====
// configuration registers: delimiter map and grouping flag
module qft_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [qft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qft_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output qft_pkg::csr_type                    csr
);

   logic [qft_pkg::CSR_DATA_W-1:0] map_low_ff, map_low_in;
   logic [qft_pkg::CSR_DATA_W-1:0] map_mid_low_ff, map_mid_low_in;
   logic [qft_pkg::CSR_DATA_W-1:0] map_mid_high_ff, map_mid_high_in;
   logic [qft_pkg::CSR_DATA_W-1:0] map_high_ff, map_high_in;
   logic                           group_ff, group_in;

   always_comb begin
      map_low_in      = map_low_ff;
      map_mid_low_in  = map_mid_low_ff;
      map_mid_high_in = map_mid_high_ff;
      map_high_in     = map_high_ff;
      group_in        = group_ff;
      if (csr_wr_en) begin
         case (csr_index)
            qft_pkg::CSR_MAP_LOW:      map_low_in      = csr_wr_data;
            qft_pkg::CSR_MAP_MID_LOW:  map_mid_low_in  = csr_wr_data;
            qft_pkg::CSR_MAP_MID_HIGH: map_mid_high_in = csr_wr_data;
            qft_pkg::CSR_MAP_HIGH:     map_high_in     = csr_wr_data;
            qft_pkg::CSR_GROUP:        group_in        = csr_wr_data[0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff      <= '0;
         map_mid_low_ff  <= '0;
         map_mid_high_ff <= '0;
         map_high_ff     <= '0;
         group_ff        <= 1'b0;
      end else begin
         map_low_ff      <= map_low_in;
         map_mid_low_ff  <= map_mid_low_in;
         map_mid_high_ff <= map_mid_high_in;
         map_high_ff     <= map_high_in;
         group_ff        <= group_in;
      end
   end

   assign csr.delim_map    = {map_high_ff, map_mid_high_ff, map_mid_low_ff, map_low_ff};
   assign csr.group_delims = group_ff;

endmodule

// ===== sv/qft_front.sv =====
// front stage: accepts bytes and classifies them against the delimiter map
module qft_front (
   input  logic               clock,
   input  logic               reset,
   qft_req_if.sink            req_ch,
   input  qft_pkg::csr_type   csr,
   input  logic               queue_full,
   output logic               push,
   output qft_pkg::item_type  push_item
);

   logic               stage_valid_ff, stage_valid_in;
   qft_pkg::item_type  stage_ff, stage_in;
   logic               accept;

   assign push         = stage_valid_ff && !queue_full;
   assign req_ch.ready = !stage_valid_ff || !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_item    = stage_ff;

   always_comb begin
      stage_in.ch        = req_ch.char_in;
      stage_in.last      = req_ch.last_char;
      // nul always counts as a delimiter, whatever the map holds
      stage_in.is_delim  = (req_ch.char_in == qft_pkg::CH_NUL) ||
                           csr.delim_map[req_ch.char_in];
      stage_in.is_bslash = (req_ch.char_in == qft_pkg::CH_BSLASH);
      stage_in.is_squote = (req_ch.char_in == qft_pkg::CH_SQUOTE);
      stage_in.is_dquote = (req_ch.char_in == qft_pkg::CH_DQUOTE);

      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== sv/qft_fifo.sv =====
// short queue of classified bytes between front and back
module qft_fifo #(
   parameter int unsigned Depth = qft_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qft_pkg::item_type  push_item,
   input  logic               pop,
   output qft_pkg::item_type  head,
   output logic               full,
   output logic               empty
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   qft_pkg::item_type mem [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

// ===== sv/qft_back.sv =====
// back stage: quote/escape tracking, delimiter grouping and result register
module qft_back (
   input  logic               clock,
   input  logic               reset,
   input  qft_pkg::csr_type   csr,
   input  qft_pkg::item_type  head,
   input  logic               empty,
   output logic               pop,
   qft_rsp_if.source          rsp_ch
);

   qft_pkg::quote_type quote_ff, quote_in;
   logic               skip_ff, skip_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [qft_pkg::CHAR_W-1:0] out_char_ff;
   logic                       out_char_valid_ff;
   logic                       field_end_ff;
   logic                       stream_end_ff;

   logic emit;
   logic fend;
   logic has_rsp;

   assign pop = !empty && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      qft_pkg::quote_type own;
      own      = head.is_squote ? qft_pkg::QM_SINGLE : qft_pkg::QM_DOUBLE;
      emit     = 1'b0;
      fend     = 1'b0;
      quote_in = quote_ff;
      skip_in  = skip_ff;

      if (skip_ff && head.is_delim) begin
         // swallowed inside a delimiter group
      end else begin
         skip_in = 1'b0;
         if (head.is_bslash) begin
            // repeated backslash stays in escape mode
            if (quote_ff == qft_pkg::QM_NONE) begin
               quote_in = qft_pkg::QM_ESC;
            end else begin
               emit = 1'b1;
            end
         end else if (head.is_squote || head.is_dquote) begin
            if (quote_ff == qft_pkg::QM_NONE) begin
               quote_in = own;
            end else if (quote_ff == own) begin
               quote_in = qft_pkg::QM_NONE;
            end else begin
               emit = 1'b1;
               if (quote_ff == qft_pkg::QM_ESC) begin
                  quote_in = qft_pkg::QM_NONE;
               end
            end
         end else if (quote_ff == qft_pkg::QM_NONE && head.is_delim) begin
            fend = 1'b1;
            if (csr.group_delims) begin
               skip_in = 1'b1;
            end
         end else begin
            emit = 1'b1;
            if (quote_ff == qft_pkg::QM_ESC) begin
               quote_in = qft_pkg::QM_NONE;
            end
         end
         if (head.last) begin
            fend = 1'b1;
         end
      end

      // end of line drops any open quote or escape
      if (head.last) begin
         quote_in = qft_pkg::QM_NONE;
         skip_in  = 1'b0;
      end

      has_rsp = emit || fend || head.last;

      if (pop && has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff     <= qft_pkg::QM_NONE;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            quote_ff <= quote_in;
            skip_ff  <= skip_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_rsp) begin
         out_char_ff       <= emit ? head.ch : '0;
         out_char_valid_ff <= emit;
         field_end_ff      <= fend;
         stream_end_ff     <= head.last;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_char       = out_char_ff;
   assign rsp_ch.out_char_valid = out_char_valid_ff;
   assign rsp_ch.field_end      = field_end_ff;
   assign rsp_ch.stream_end     = stream_end_ff;

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> (quote_ff == qft_pkg::QM_NONE) && !skip_ff)
      else $error("mode not cleared after line end");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> rsp_valid_ff && stream_end_ff)
      else $error("final byte produced no result");

endmodule

// ===== sv/quoted_field_tokenizer_unit.sv =====
// top level of the quoted field tokenizer
//
// Splits a byte stream into fields, one byte per beat, with a sustained rate
// of one byte per clock cycle when neither side stalls; results for
// consecutive bytes follow each other on back-to-back cycles. From its input
// beat to its result beat a byte passes the classify register (the 256-entry
// delimiter map lookup), the queue and the output register, where the
// quote/escape mode update sits. The queue of QueueDepth entries (at least 2)
// lets input and output stall independently. Bytes that produce nothing
// (quote and escape characters, swallowed delimiters) give no result beat.
// Configuration writes are taken at any time and must only be issued while
// the unit is idle.
module quoted_field_tokenizer_unit #(
   parameter int unsigned QueueDepth = qft_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   qft_req_if.sink                         req_ch,
   qft_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [qft_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qft_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   qft_pkg::csr_type  csr;
   qft_pkg::item_type push_item;
   qft_pkg::item_type head;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;

   qft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .csr         (csr)
   );

   qft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr        (csr),
      .queue_full (full),
      .push       (push),
      .push_item  (push_item)
   );

   qft_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   qft_back u_back (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sim/qft_token_checker.sv =====
`timescale 1ns / 1ps
// token checker: predicts the tokenizer's result beats and compares them
module qft_token_checker
   import qft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   qft_req_if                    req_mon,
   qft_rsp_if                    rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    tokens_pending
);

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_char_valid;
      logic              field_end;
      logic              stream_end;
   } token_beat_type;

   logic [MAP_W-1:0] delim_map;
   logic             group_delims;
   quote_type        quote_mode;
   logic             skipping;
   token_beat_type   tokens_due[$];

   task automatic tokenize_byte(input logic [CHAR_W-1:0] ch, input logic line_end);
      token_beat_type beat;
      quote_type      own;
      logic           emit;
      logic           fend;
      logic           is_delim;
      emit = 1'b0;
      fend = 1'b0;
      // nul is a separator whatever the map holds
      is_delim = (ch == CH_NUL) || delim_map[ch];
      if (!(skipping && is_delim)) begin
         skipping = 1'b0;
         if (ch == CH_BSLASH) begin
            if (quote_mode == QM_NONE)
               quote_mode = QM_ESC;
            else
               emit = 1'b1;
         end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
            if (ch == CH_SQUOTE)
               own = QM_SINGLE;
            else
               own = QM_DOUBLE;
            if (quote_mode == QM_NONE) begin
               quote_mode = own;
            end else if (quote_mode == own) begin
               quote_mode = QM_NONE;
            end else begin
               emit = 1'b1;
               if (quote_mode == QM_ESC)
                  quote_mode = QM_NONE;
            end
         end else if (quote_mode == QM_NONE && is_delim) begin
            fend = 1'b1;
            if (group_delims)
               skipping = 1'b1;
         end else begin
            emit = 1'b1;
            if (quote_mode == QM_ESC)
               quote_mode = QM_NONE;
         end
         if (line_end)
            fend = 1'b1;
      end
      // an open quote or escape dies with the line
      if (line_end) begin
         quote_mode = QM_NONE;
         skipping   = 1'b0;
      end
      if (emit || fend || line_end) begin
         beat.out_char       = emit ? ch : '0;
         beat.out_char_valid = emit;
         beat.field_end      = fend;
         beat.stream_end     = line_end;
         tokens_due = {tokens_due, beat};
      end
   endtask

   task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                              input logic [CHAR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      token_beat_type due;
      if (reset) begin
         delim_map    = '0;
         group_delims = 1'b0;
         quote_mode   = QM_NONE;
         skipping     = 1'b0;
         tokens_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAP_LOW:      delim_map[0*CSR_DATA_W +: CSR_DATA_W] = csr_wr_data;
               CSR_MAP_MID_LOW:  delim_map[1*CSR_DATA_W +: CSR_DATA_W] = csr_wr_data;
               CSR_MAP_MID_HIGH: delim_map[2*CSR_DATA_W +: CSR_DATA_W] = csr_wr_data;
               CSR_MAP_HIGH:     delim_map[3*CSR_DATA_W +: CSR_DATA_W] = csr_wr_data;
               CSR_GROUP:        group_delims = csr_wr_data[0];
               default: ;
            endcase
         end
         // compare before predicting so a beat cannot match its own byte
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tokens_due.size() == 0) begin
               $error("result beat with no byte pending: out_char %0h valid %0b end %0b/%0b",
                      rsp_mon.out_char, rsp_mon.out_char_valid, rsp_mon.field_end,
                      rsp_mon.stream_end);
               mismatch_count++;
            end else begin
               due = tokens_due.pop_front();
               check_field("out_char", due.out_char, rsp_mon.out_char);
               check_field("out_char_valid", due.out_char_valid, rsp_mon.out_char_valid);
               check_field("field_end", due.field_end, rsp_mon.field_end);
               check_field("stream_end", due.stream_end, rsp_mon.stream_end);
            end
         end
         if (req_mon.valid && req_mon.ready)
            tokenize_byte(req_mon.char_in, req_mon.last_char);
      end
      tokens_pending = tokens_due.size();
   end

endmodule

// ===== sim/tb_quoted_field_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the quoted field tokenizer
module tb_quoted_field_tokenizer_unit;
   import qft_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_TOP        = 8'hFF;
   localparam logic [CHAR_W-1:0] CH_HIGH_PLAIN = 8'h80;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int mismatch_count;
   int tokens_pending;
   int cycle_count;
   int req_gap_max;
   int rsp_stall_max;
   int rsp_wait;
   int bytes_sent;

   logic [CHAR_W-1:0] delim_pool[8];

   qft_req_if req_ch();
   qft_rsp_if rsp_ch();

   quoted_field_tokenizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   qft_token_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_quoted_field_tokenizer_unit: done, errors");
         $finish;
      end
   end

   // result side: randomly stall ready after each beat
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         rsp_wait     <= 0;
      end else if (!rsp_ch.ready) begin
         if (rsp_wait == 0)
            rsp_ch.ready <= 1'b1;
         else
            rsp_wait <= rsp_wait - 1;
      end else if (rsp_ch.valid) begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= stall - 1;
         end
      end
   end

   task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic line_end);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_in   <= ch;
      req_ch.last_char <= line_end;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_line(input logic [CHAR_W-1:0] line_q[$]);
      foreach (line_q[i])
         send_beat(line_q[i], i == line_q.size() - 1);
      bytes_sent += line_q.size();
   endtask

   // hold off until every result is back and the pipe has emptied
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_tokenizer(input logic [MAP_W-1:0] map, input logic grp);
      logic [CSR_DATA_W-1:0] junk;
      for (int w = 0; w < 4; w++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_MAP_LOW + CSR_IDX_W'(w);
         csr_wr_data <= map[w*CSR_DATA_W +: CSR_DATA_W];
         @(posedge clock);
      end
      junk    = {$urandom, $urandom};
      junk[0] = grp;
      csr_index   <= CSR_GROUP;
      csr_wr_data <= junk;
      @(posedge clock);
      // an index past the last register must change nothing
      csr_index   <= CSR_GROUP +
                     CSR_IDX_W'($urandom_range(1, 2**CSR_IDX_W - 1 - CSR_GROUP));
      csr_wr_data <= {$urandom, $urandom};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic draw_sparse_map(output logic [MAP_W-1:0] map);
      map = '0;
      map[CH_SPACE] = 1'b1;
      for (int i = 0; i < 8; i++) begin
         delim_pool[i] = CHAR_W'($urandom_range(0, 255));
         map[delim_pool[i]] = 1'b1;
      end
   endtask

   // a line built from words, separator runs, quoted spans, escapes and nul
   task automatic send_random_line();
      logic [CHAR_W-1:0] line_q[$];
      logic [CHAR_W-1:0] quote;
      int                n_parts;
      n_parts = $urandom_range(1, 6);
      repeat (n_parts) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(1, 5)) line_q = {line_q, CHAR_W'($urandom_range(0, 255))};
            end
            4, 5: begin
               repeat ($urandom_range(1, 3))
                  line_q = {line_q, delim_pool[3'($urandom_range(0, 7))]};
            end
            6, 7: begin
               quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
               line_q = {line_q, quote};
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 1))
                     line_q = {line_q, delim_pool[3'($urandom_range(0, 7))]};
                  else
                     line_q = {line_q, CHAR_W'($urandom_range(0, 255))};
               end
               // now and then leave the quote open
               if ($urandom_range(0, 9) != 0)
                  line_q = {line_q, quote};
            end
            8: begin
               line_q = {line_q, CH_BSLASH};
               if ($urandom_range(0, 3) == 0)
                  line_q = {line_q, CH_BSLASH};
               line_q = {line_q, CHAR_W'($urandom_range(0, 255))};
            end
            default: begin
               line_q = {line_q, CH_NUL};
            end
         endcase
      end
      send_line(line_q);
   endtask

   task automatic run_phase(input logic [MAP_W-1:0] map, input logic grp, input int n_bytes);
      int goal;
      goal = bytes_sent + n_bytes;
      settle();
      program_tokenizer(map, grp);
      while (bytes_sent < goal) send_random_line();
   endtask

   initial begin
      logic [MAP_W-1:0]  map;
      logic [CHAR_W-1:0] line_q[$];
      string             text;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_MAP_LOW;
      csr_wr_data      <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.char_in   <= '0;
      req_ch.last_char <= 1'b0;
      req_gap_max   = 3;
      rsp_stall_max = 3;
      bytes_sent    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // quote and escape bytes flagged in the map must still not split fields
      map = '0;
      map[CH_SPACE]  = 1'b1;
      map[CH_COMMA]  = 1'b1;
      map[CH_BSLASH] = 1'b1;
      map[CH_SQUOTE] = 1'b1;
      map[CH_DQUOTE] = 1'b1;
      map[CH_TOP]    = 1'b1;
      settle();
      program_tokenizer(map, 1'b0);
      // nul, repeated backslash, escaped space, both quote kinds, empty field
      text = "a\\\\\\ b'\" \\'\"'\\\" ";
      line_q = {CH_NUL};
      for (int i = 0; i < text.len(); i++) line_q = {line_q, text[i]};
      line_q = {line_q, CH_TOP};
      line_q = {line_q, CH_HIGH_PLAIN};
      line_q = {line_q, CH_COMMA};
      send_line(line_q);

      // every byte a separator with grouping: last byte swallowed, then open quote
      settle();
      program_tokenizer('1, 1'b1);
      text = "ab\\c";
      line_q = {};
      for (int i = 0; i < text.len(); i++) line_q = {line_q, text[i]};
      send_line(line_q);
      text = "'z\\";
      line_q = {};
      for (int i = 0; i < text.len(); i++) line_q = {line_q, text[i]};
      send_line(line_q);

      draw_sparse_map(map);
      run_phase('0, 1'b0, 200);
      run_phase('1, 1'b1, 150);
      req_gap_max   = 0;
      rsp_stall_max = 0;
      draw_sparse_map(map);
      run_phase(map, 1'b1, 250);
      req_gap_max   = 3;
      rsp_stall_max = 3;
      draw_sparse_map(map);
      run_phase(map, 1'b0, 250);
      map = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      run_phase(map, 1'($urandom_range(0, 1)), 150);
      req_gap_max = 0;
      draw_sparse_map(map);
      run_phase(map, 1'b1, 150);

      settle();
      if (mismatch_count == 0)
         $display("tb_quoted_field_tokenizer_unit: done, clean");
      else
         $display("tb_quoted_field_tokenizer_unit: done, errors");
      $finish;
   end

endmodule
